[rtl/fvn_pkg.sv]
// ============================================================================
// Fractal value noise package
// Shared widths, hash constants, register indexes and small helper functions
// for the fractal value noise block.
// ============================================================================
package fvn_pkg;

  localparam int MUL_W     = 34;
  localparam int PROD_W    = 64;
  localparam int QUO_W     = 16;
  localparam int AMP_W     = 17;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [MUL_W-1:0] mul_op_t;
  typedef logic [PROD_W-1:0]       prod_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED       = 3'd0,
    CFG_OCTAVES    = 3'd1,
    CFG_BASE_FREQ  = 3'd2,
    CFG_LACUNARITY = 3'd3,
    CFG_GAIN       = 3'd4
  } cfg_reg_t;

  localparam logic [31:0] HASH_MUL_SQ  = 32'd15731;
  localparam logic [31:0] HASH_ADD1    = 32'd789221;
  localparam logic [31:0] HASH_ADD2    = 32'd1376312589;
  localparam logic [31:0] HASH_MASK    = 32'h7fff_ffff;
  localparam logic [31:0] LATTICE_BIAS = 32'h4000_0000;
  localparam logic [31:0] Y_STRIDE     = 32'd57;
  localparam logic [31:0] SEED_STEP131 = 32'd131000;
  localparam logic [17:0] SMOOTH_T3    = 18'd196608;
  localparam logic [AMP_W-1:0] AMP_ONE = 17'd65536;
  localparam logic [15:0] OUT_MAX      = 16'd16384;

  function automatic logic [31:0] hash_mix(input logic [31:0] h);
    return h ^ {h[18:0], 13'b0};
  endfunction

  function automatic logic [31:0] mul57(input logic [31:0] v);
    return {v[25:0], 6'b0} - {v[28:0], 3'b0} + v;
  endfunction

  function automatic logic [31:0] mul131(input logic [31:0] v);
    return {v[24:0], 7'b0} + {v[30:0], 1'b0} + v;
  endfunction

endpackage

[rtl/fractal_value_noise_2d.sv]
// ============================================================================
// Fractal value noise, 2D
// Sums octaves of lattice value noise at a fixed-point coordinate and returns
// the amplitude-weighted mean in Q2.14.
//
//   channel  direction  signals                                  payload
//   in       sink       in_valid, in_ready                       x_coord, y_coord
//   out      source     out_valid, out_ready                     noise_value
//   cfg      sink       cfg_valid, cfg_ready, cfg_index          cfg_data
//
// A transaction runs the octave loop N times, N being the octave count after
// saturation to 1..MAX_OCTAVES. All products share the single multiplier:
// every scaling, hash, smoothstep, interpolation and weighting product passes
// through it one per cycle, and an iterative divider forms the final mean.
// Reset restores the register defaults and idles the sequencer.
// A result waits in the output register; the sequencer holds in its last
// state until that register is free.
// ============================================================================
module fractal_value_noise_2d #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [31:0]            x_coord,
  input  logic signed [31:0]            y_coord,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            noise_value,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fvn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import fvn_pkg::*;

  localparam int CNT_W  = $clog2(MAX_OCTAVES + 1);
  localparam int ASUM_W = AMP_W + CNT_W;
  localparam int TOT_W  = 48 + CNT_W;
  localparam int DEN_W  = ASUM_W + 16;

  typedef enum logic [28:0] {
    S_IDLE = 29'd1 << 0,
    S_SCX  = 29'd1 << 1,
    S_SCY  = 29'd1 << 2,
    S_SCW  = 29'd1 << 3,
    S_OCT  = 29'd1 << 4,
    S_H0   = 29'd1 << 5,
    S_H1   = 29'd1 << 6,
    S_H2   = 29'd1 << 7,
    S_H3   = 29'd1 << 8,
    S_H4   = 29'd1 << 9,
    S_S0   = 29'd1 << 10,
    S_S1   = 29'd1 << 11,
    S_S2   = 29'd1 << 12,
    S_S3   = 29'd1 << 13,
    S_S4   = 29'd1 << 14,
    S_L1   = 29'd1 << 15,
    S_L2   = 29'd1 << 16,
    S_L3   = 29'd1 << 17,
    S_L4   = 29'd1 << 18,
    S_ACC  = 29'd1 << 19,
    S_AMP  = 29'd1 << 20,
    S_LX0  = 29'd1 << 21,
    S_LX1  = 29'd1 << 22,
    S_LX2  = 29'd1 << 23,
    S_LY1  = 29'd1 << 24,
    S_LY2  = 29'd1 << 25,
    S_DIV  = 29'd1 << 26,
    S_WDIV = 29'd1 << 27,
    S_FIN  = 29'd1 << 28
  } state_t;

  state_t state;
  state_t state_next;

  logic [31:0] seed;
  logic [3:0]  octave_count;
  logic [23:0] base_frequency;
  logic [15:0] lacunarity;
  logic [15:0] gain;

  logic [31:0]        x_in;
  logic [31:0]        y_in;
  logic [47:0]        cx;
  logic [47:0]        cy;
  logic [31:0]        hb;
  logic [31:0]        hreg;
  logic [31:0]        corner [4];
  logic [1:0]         cidx;
  logic [AMP_W-1:0]   wu;
  logic [AMP_W-1:0]   wv;
  logic [31:0]        ab0;
  logic [31:0]        ab1;
  logic [31:0]        val;
  logic [AMP_W-1:0]   amp;
  logic [ASUM_W-1:0]  amp_sum;
  logic [TOT_W-1:0]   total;
  logic [31:0]        tmp;
  logic [31:0]        s131;
  logic [CNT_W-1:0]   k;
  logic [CNT_W-1:0]   oct_num;

  mul_op_t mul_a;
  mul_op_t mul_b;
  prod_t   prod;

  div_stat_t        div_stat;
  logic [QUO_W-1:0] div_quo;
  logic [TOT_W-1:0] mag;
  logic [TOT_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;

  logic [4:0]  oc5;
  logic [4:0]  n5;
  logic        last_oct;
  logic [1:0]  cidx_inc;
  logic [31:0] corner_off_next;
  logic [31:0] hsum;
  logic [31:0] lat_val;
  logic [47:0] coord_lac;
  logic [47:0] coord_scaled;
  logic [31:0] lerp_step;
  logic [32:0] d_x0;
  logic [32:0] d_x1;
  logic [32:0] d_y;
  logic [15:0] q_clamp;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign oc5 = {1'b0, octave_count};
  always_comb begin
    priority if (oc5 == 5'd0) begin
      n5 = 5'd1;
    end else if (oc5 > 5'(MAX_OCTAVES)) begin
      n5 = 5'(MAX_OCTAVES);
    end else begin
      n5 = oc5;
    end
  end

  assign last_oct        = (k == oct_num - 1'b1);
  assign cidx_inc        = cidx + 2'd1;
  assign corner_off_next = 32'(cidx_inc[0]) + (cidx_inc[1] ? Y_STRIDE : 32'd0);
  assign hsum            = prod[31:0] + HASH_ADD2;
  assign lat_val         = LATTICE_BIAS - (hsum & HASH_MASK);
  assign coord_lac       = {prod[43:0], 4'b0} + {28'b0, tmp[31:12]};
  assign coord_scaled    = {{8{prod[55]}}, prod[55:16]};
  assign lerp_step       = prod[47:16];
  assign d_x0            = {corner[1][31], corner[1]} - {corner[0][31], corner[0]};
  assign d_x1            = {corner[3][31], corner[3]} - {corner[2][31], corner[2]};
  assign d_y             = {ab1[31], ab1} - {ab0[31], ab0};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SCX: begin
        mul_a = MUL_W'($signed(x_in));
        mul_b = MUL_W'(base_frequency);
      end
      S_SCY: begin
        mul_a = MUL_W'($signed(y_in));
        mul_b = MUL_W'(base_frequency);
      end
      S_H1: begin
        mul_a = MUL_W'(hreg);
        mul_b = MUL_W'(hreg);
      end
      S_H2: begin
        mul_a = MUL_W'(prod[31:0]);
        mul_b = MUL_W'(HASH_MUL_SQ);
      end
      S_H3: begin
        mul_a = MUL_W'(hreg);
        mul_b = MUL_W'(prod[31:0] + HASH_ADD1);
      end
      S_S0: begin
        mul_a = MUL_W'(cx[15:0]);
        mul_b = MUL_W'(cx[15:0]);
      end
      S_S1: begin
        mul_a = MUL_W'(prod[31:16]);
        mul_b = MUL_W'(SMOOTH_T3 - {1'b0, cx[15:0], 1'b0});
      end
      S_S2: begin
        mul_a = MUL_W'(cy[15:0]);
        mul_b = MUL_W'(cy[15:0]);
      end
      S_S3: begin
        mul_a = MUL_W'(prod[31:16]);
        mul_b = MUL_W'(SMOOTH_T3 - {1'b0, cy[15:0], 1'b0});
      end
      S_S4: begin
        mul_a = MUL_W'($signed(d_x0));
        mul_b = MUL_W'(wu);
      end
      S_L1: begin
        mul_a = MUL_W'($signed(d_x1));
        mul_b = MUL_W'(wu);
      end
      S_L3: begin
        mul_a = MUL_W'($signed(d_y));
        mul_b = MUL_W'(wv);
      end
      S_ACC: begin
        mul_a = MUL_W'($signed(val));
        mul_b = MUL_W'(amp);
      end
      S_AMP: begin
        mul_a = MUL_W'(amp);
        mul_b = MUL_W'(gain);
      end
      S_LX0: begin
        mul_a = MUL_W'(cx[15:0]);
        mul_b = MUL_W'(lacunarity);
      end
      S_LX1: begin
        mul_a = MUL_W'($signed(cx[47:16]));
        mul_b = MUL_W'(lacunarity);
      end
      S_LX2: begin
        mul_a = MUL_W'(cy[15:0]);
        mul_b = MUL_W'(lacunarity);
      end
      S_LY1: begin
        mul_a = MUL_W'($signed(cy[47:16]));
        mul_b = MUL_W'(lacunarity);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_SCX;
      S_SCX:  state_next = S_SCY;
      S_SCY:  state_next = S_SCW;
      S_SCW:  state_next = S_OCT;
      S_OCT:  state_next = S_H0;
      S_H0:   state_next = S_H1;
      S_H1:   state_next = S_H2;
      S_H2:   state_next = S_H3;
      S_H3:   state_next = S_H4;
      S_H4:   state_next = (cidx == 2'd3) ? S_S0 : S_H1;
      S_S0:   state_next = S_S1;
      S_S1:   state_next = S_S2;
      S_S2:   state_next = S_S3;
      S_S3:   state_next = S_S4;
      S_S4:   state_next = S_L1;
      S_L1:   state_next = S_L2;
      S_L2:   state_next = S_L3;
      S_L3:   state_next = S_L4;
      S_L4:   state_next = S_ACC;
      S_ACC:  state_next = S_AMP;
      S_AMP:  state_next = S_LX0;
      S_LX0:  state_next = S_LX1;
      S_LX1:  state_next = S_LX2;
      S_LX2:  state_next = S_LY1;
      S_LY1:  state_next = S_LY2;
      S_LY2:  state_next = last_oct ? S_DIV : S_OCT;
      S_DIV:  state_next = S_WDIV;
      S_WDIV: if (div_stat.done) state_next = S_FIN;
      S_FIN:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      cidx           <= '0;
      k              <= '0;
      oct_num        <= '0;
      seed           <= '0;
      octave_count   <= 4'd4;
      base_frequency <= 24'd65536;
      lacunarity     <= 16'd8192;
      gain           <= 16'd32768;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end
      if (state == S_IDLE && in_valid) begin
        k       <= '0;
        oct_num <= CNT_W'(n5);
      end
      if (state == S_OCT) begin
        cidx <= '0;
      end
      if (state == S_H4 && cidx != 2'd3) begin
        cidx <= cidx_inc;
      end
      if (state == S_LY2 && !last_oct) begin
        k <= k + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SEED:       seed           <= cfg_data;
          CFG_OCTAVES:    octave_count   <= cfg_data[3:0];
          CFG_BASE_FREQ:  base_frequency <= cfg_data[23:0];
          CFG_LACUNARITY: lacunarity     <= cfg_data[15:0];
          CFG_GAIN:       gain           <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        x_in    <= x_coord;
        y_in    <= y_coord;
        amp     <= AMP_ONE;
        amp_sum <= '0;
        total   <= '0;
        s131    <= mul131(seed);
      end
      S_SCY: cx <= coord_scaled;
      S_SCW: cy <= coord_scaled;
      S_OCT: hb <= cx[47:16] + mul57(cy[47:16]) + s131;
      S_H0:  hreg <= hash_mix(hb);
      S_H4: begin
        corner[cidx] <= lat_val;
        hreg         <= hash_mix(hb + corner_off_next);
      end
      S_S2:  wu <= prod[32:16];
      S_S4:  wv <= prod[32:16];
      S_L1:  ab0 <= corner[0] + lerp_step;
      S_L2:  ab1 <= corner[2] + lerp_step;
      S_L4:  val <= ab0 + lerp_step;
      S_AMP: begin
        total   <= total + prod[TOT_W-1:0];
        amp_sum <= amp_sum + ASUM_W'(amp);
      end
      S_LX0: amp <= prod[32:16];
      S_LX1: tmp <= prod[31:0];
      S_LX2: cx  <= coord_lac;
      S_LY1: tmp <= prod[31:0];
      S_LY2: begin
        cy   <= coord_lac;
        s131 <= s131 + SEED_STEP131;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          noise_value <= total[TOT_W-1] ? -q_clamp : q_clamp;
        end
      end
      default: ;
    endcase
  end

  assign mag     = total[TOT_W-1] ? -total : total;
  assign div_num = mag + TOT_W'({amp_sum, 15'b0});
  assign div_den = {amp_sum, 16'b0};
  assign q_clamp = (div_quo > OUT_MAX) ? OUT_MAX : div_quo;

  fvn_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  fvn_div #(
    .NUM_W (TOT_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DIV),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (div_quo)
  );

`ifndef ASSERT_OFF
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !div_stat.busy)
    else $error("Divider is busy while the block accepts a transaction.");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == S_WDIV)
    else $error("Divider finished outside the wait state.");

  a_octave_bound: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE && state != S_SCX |-> k < oct_num)
    else $error("Octave counter ran past the octave count.");

  a_weight_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> amp_sum != '0)
    else $error("Division started with a zero amplitude sum.");
`endif

endmodule

[rtl/fvn_mul.sv]
// ============================================================================
// Shared multiplier
// Signed multiplier with a registered product, time-shared by the sequencer
// for scaling, hashing, smoothstep, interpolation and weighting.
// ============================================================================
module fvn_mul (
  input  logic            clk,
  input  fvn_pkg::mul_op_t a,
  input  fvn_pkg::mul_op_t b,
  output fvn_pkg::prod_t   prod
);
  import fvn_pkg::*;

  logic signed [2*MUL_W-1:0] full;

  assign full = a * b;

  always_ff @(posedge clk) begin
    prod <= full[PROD_W-1:0];
  end

endmodule

[rtl/fvn_div.sv]
// ============================================================================
// Iterative divider
// Restoring divider that yields one quotient bit per cycle. The caller
// guarantees that the quotient fits in QUO_W bits.
// ============================================================================
module fvn_div #(
  parameter int NUM_W = 52,
  parameter int DEN_W = 37
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [NUM_W-1:0]          num,
  input  logic [DEN_W-1:0]          den,
  output fvn_pkg::div_stat_t        stat,
  output logic [fvn_pkg::QUO_W-1:0] quo
);
  import fvn_pkg::*;

  localparam int SH_W  = DEN_W + QUO_W - 1;
  localparam int CMP_W = (NUM_W > SH_W) ? NUM_W : SH_W;
  localparam int CNT_W = $clog2(QUO_W);

  logic [NUM_W-1:0] rem;
  logic [SH_W-1:0]  dsh;
  logic [CNT_W-1:0] cnt;
  logic [CMP_W-1:0] rem_ext;
  logic [CMP_W-1:0] dsh_ext;
  logic             fits;

  assign rem_ext = CMP_W'(rem);
  assign dsh_ext = CMP_W'(dsh);
  assign fits    = rem_ext >= dsh_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= CNT_W'(QUO_W - 1);
      end else if (stat.busy) begin
        if (cnt == '0) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsh <= {den, {(QUO_W-1){1'b0}}};
    end else if (stat.busy) begin
      if (fits) begin
        rem <= NUM_W'(rem_ext - dsh_ext);
      end
      quo <= {quo[QUO_W-2:0], fits};
      dsh <= dsh >> 1;
    end
  end

endmodule

[test/fractal_value_noise_2d_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// Fractal value noise testbench
// Streams coordinates through the block under several register settings and
// idling patterns. Every accepted coordinate is scored against a fixed-point
// model of the octave sum, and each output transaction is compared with the
// oldest outstanding prediction.
// ============================================================================
module fractal_value_noise_2d_tb;
  import fvn_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int MAX_OCTAVES = 8;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE_CYCLES = 400;

  localparam int IDLE_NONE     = 0;
  localparam int IDLE_SENDER   = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 3'd5;

  localparam logic [31:0] SEED_MASK = 32'hFFFF_FFFF;
  localparam logic [31:0] OCT_MASK  = 32'h0000_000F;
  localparam logic [31:0] FREQ_MASK = 32'h00FF_FFFF;
  localparam logic [31:0] HALF_MASK = 32'h0000_FFFF;

  localparam logic [31:0] ROW_STEP     = 32'd57;
  localparam logic [31:0] SEED_MUL     = 32'd131;
  localparam logic [31:0] OCTAVE_SEED  = 32'd1000;
  localparam logic [31:0] CUBE_MUL     = 32'd15731;
  localparam logic [31:0] CUBE_ADD     = 32'd789221;
  localparam logic [31:0] FINAL_ADD    = 32'd1376312589;
  localparam longint      VALUE_BIAS   = 64'sd1073741824;
  localparam longint      UNIT_AMP     = 64'sd65536;
  localparam longint      NOISE_LIMIT  = 64'sd16384;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } coord_t;

  typedef struct {
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          data;
  } reg_write_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [31:0]   x_coord = '0;
  logic signed [31:0]   y_coord = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [15:0]   noise_value;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  logic        in_fire = 1'b0;
  logic        cfg_fire = 1'b0;
  int          cycle_count = 0;
  int          error_count = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;

  logic [31:0] seed_r;
  logic [3:0]  octaves_r;
  logic [23:0] base_freq_r;
  logic [15:0] lacunarity_r;
  logic [15:0] gain_r;

  coord_t             coord_q[$];
  reg_write_t         reg_write_q[$];
  logic signed [15:0] noise_expect_q[$];

  fractal_value_noise_2d #(
    .MAX_OCTAVES(MAX_OCTAVES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .x_coord(x_coord),
    .y_coord(y_coord),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .noise_value(noise_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic longint lattice_value(logic [31:0] ix, logic [31:0] iy, logic [31:0] s);
    logic [31:0] h;
    logic [31:0] m;
    longint      mv;
    h = ix + iy * ROW_STEP + s * SEED_MUL;
    h = h ^ (h << 13);
    m = h * (h * h * CUBE_MUL + CUBE_ADD) + FINAL_ADD;
    m[31] = 1'b0;
    mv = m;
    return VALUE_BIAS - mv;
  endfunction

  function automatic logic [31:0] smooth_weight(logic [15:0] f);
    logic [63:0] f2;
    logic [63:0] t;
    f2 = ({48'b0, f} * {48'b0, f}) >> 16;
    t = 64'd196608 - {47'b0, f, 1'b0};
    return 32'((f2 * t) >> 16);
  endfunction

  function automatic longint blend(longint a, longint b, logic [31:0] w);
    longint wl;
    wl = w;
    return a + (((b - a) * wl) >>> 16);
  endfunction

  function automatic longint octave_value(logic [47:0] cx, logic [47:0] cy, logic [31:0] s);
    logic [31:0] ix;
    logic [31:0] iy;
    logic [31:0] u;
    logic [31:0] v;
    longint      near_row;
    longint      far_row;
    ix = cx[47:16];
    iy = cy[47:16];
    u = smooth_weight(cx[15:0]);
    v = smooth_weight(cy[15:0]);
    near_row = blend(lattice_value(ix, iy, s), lattice_value(ix + 32'd1, iy, s), u);
    far_row = blend(lattice_value(ix, iy + 32'd1, s),
                    lattice_value(ix + 32'd1, iy + 32'd1, s), u);
    return blend(near_row, far_row, v);
  endfunction

  function automatic logic [47:0] next_octave_coord(logic [47:0] c, logic [15:0] lac);
    logic [63:0] p;
    p = {{16{c[47]}}, c} * {48'b0, lac};
    return p[59:12];
  endfunction

  function automatic logic [47:0] base_coord(logic [31:0] c, logic [23:0] freq);
    logic [63:0] p;
    p = {{32{c[31]}}, c} * {40'b0, freq};
    return p[63:16];
  endfunction

  function automatic logic signed [15:0] predict_noise(logic [31:0] x, logic [31:0] y);
    logic [47:0] cx;
    logic [47:0] cy;
    logic [31:0] s;
    longint      total;
    longint      amp_sum;
    longint      amp;
    longint      denom;
    longint      mag;
    longint      q;
    int          n;
    int          k;
    n = octaves_r;
    if (n < 1) n = 1;
    if (n > MAX_OCTAVES) n = MAX_OCTAVES;
    cx = base_coord(x, base_freq_r);
    cy = base_coord(y, base_freq_r);
    amp = UNIT_AMP;
    total = 0;
    amp_sum = 0;
    for (k = 0; k < n; k++) begin
      s = seed_r + k * OCTAVE_SEED;
      total += octave_value(cx, cy, s) * amp;
      amp_sum += amp;
      amp = (amp * gain_r) >> 16;
      cx = next_octave_coord(cx, lacunarity_r);
      cy = next_octave_coord(cy, lacunarity_r);
    end
    denom = amp_sum * UNIT_AMP;
    mag = (total < 0) ? -total : total;
    q = (mag + denom / 2) / denom;
    if (total < 0) q = -q;
    if (q > NOISE_LIMIT) q = NOISE_LIMIT;
    if (q < -NOISE_LIMIT) q = -NOISE_LIMIT;
    return 16'(q);
  endfunction

  task automatic apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    case (idx)
      CFG_SEED:       seed_r = data;
      CFG_OCTAVES:    octaves_r = data[3:0];
      CFG_BASE_FREQ:  base_freq_r = data[23:0];
      CFG_LACUNARITY: lacunarity_r = data[15:0];
      CFG_GAIN:       gain_r = data[15:0];
      default:        ;
    endcase
  endtask

  initial begin
    seed_r = '0;
    octaves_r = 4'd4;
    base_freq_r = 24'd65536;
    lacunarity_r = 16'd8192;
    gain_r = 16'd32768;
  end

  always @(posedge clk) begin : monitor
    logic signed [15:0] expected;
    cycle_count <= cycle_count + 1;
    in_fire <= !rst && in_valid && in_ready;
    cfg_fire <= !rst && cfg_valid && cfg_ready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        apply_reg_write(cfg_index, cfg_data);
      end
      if (out_valid && out_ready) begin
        if (noise_expect_q.size() == 0) begin
          $error("noise_value %0d arrived with no transaction outstanding", noise_value);
          error_count++;
        end else begin
          expected = noise_expect_q.pop_front();
          if (noise_value !== expected) begin
            $error("noise_value mismatch: expected %0d, actual %0d", expected, noise_value);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        noise_expect_q.push_back(predict_noise(x_coord, y_coord));
      end
    end
  end

  always @(negedge clk) begin : coord_driver
    coord_t c;
    if (!rst && (!in_valid || in_fire)) begin
      if (coord_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        c = coord_q.pop_front();
        in_valid <= 1'b1;
        x_coord <= c.x;
        y_coord <= c.y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : cfg_driver
    reg_write_t w;
    if (!rst && (!cfg_valid || cfg_fire)) begin
      if (reg_write_q.size() != 0) begin
        w = reg_write_q.pop_front();
        cfg_valid <= 1'b1;
        cfg_index <= w.idx;
        cfg_data <= w.data;
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic set_idling(int mode);
    case (mode)
      IDLE_SENDER:   begin src_idle_pct = 78; sink_stall_pct = 0;  end
      IDLE_RECEIVER: begin src_idle_pct = 0;  sink_stall_pct = 78; end
      IDLE_BOTH:     begin src_idle_pct = 13; sink_stall_pct = 13; end
      default:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
    endcase
  endtask

  task automatic queue_coord(logic [31:0] x, logic [31:0] y);
    coord_t c;
    c.x = x;
    c.y = y;
    coord_q.push_back(c);
  endtask

  function automatic logic [31:0] random_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 4))
      0: return r;
      1: return {{12{r[31]}}, r[19:0]};
      2: begin
        case ($urandom_range(0, 3))
          0: return {r[31:16], 16'h0000};
          1: return {r[31:16], 16'hFFFF};
          2: return {r[31:16], 16'h0001};
          default: return {r[31:16], 16'h8000};
        endcase
      end
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return {{8{r[31]}}, r[23:0]};
    endcase
  endfunction

  task automatic queue_random_coords(int count);
    int i;
    for (i = 0; i < count; i++) begin
      queue_coord(random_coord(), random_coord());
    end
  endtask

  task automatic wait_for_idle();
    while (coord_q.size() != 0 || in_valid || noise_expect_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value, logic [31:0] keep);
    reg_write_t w;
    w.idx = idx;
    w.data = ($urandom & ~keep) | (value & keep);
    reg_write_q.push_back(w);
  endtask

  task automatic program_settings(logic [31:0] seed, logic [3:0] octaves, logic [23:0] freq,
                                  logic [15:0] lac, logic [15:0] gain, bit unused_writes);
    int i;
    wait_for_idle();
    write_reg(CFG_SEED, seed, SEED_MASK);
    write_reg(CFG_OCTAVES, {28'b0, octaves}, OCT_MASK);
    write_reg(CFG_BASE_FREQ, {8'b0, freq}, FREQ_MASK);
    write_reg(CFG_LACUNARITY, {16'b0, lac}, HALF_MASK);
    write_reg(CFG_GAIN, {16'b0, gain}, HALF_MASK);
    if (unused_writes) begin
      for (i = CFG_UNUSED_FIRST; i < 2 ** CFG_IDX_W; i++) begin
        write_reg(i[CFG_IDX_W-1:0], $urandom, SEED_MASK);
      end
    end
    while (reg_write_q.size() != 0 || cfg_valid) begin
      @(negedge clk);
    end
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int          p;
    logic [3:0]  octaves;
    logic [23:0] freq;
    logic [15:0] lac;
    logic [15:0] gain;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_idling(IDLE_NONE);
    queue_coord(32'h0000_0000, 32'h0000_0000);
    queue_coord(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_coord(32'h8000_0000, 32'h8000_0000);
    queue_coord(32'h7FFF_FFFF, 32'h8000_0000);
    queue_coord(32'h8000_0000, 32'h7FFF_FFFF);
    queue_coord(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_coord(32'h0000_0001, 32'h0000_0001);
    queue_coord(32'h0000_FFFF, 32'h0001_0000);
    queue_coord(32'h0000_8000, 32'h0000_8000);
    queue_coord(32'hFFFF_0000, 32'h0001_0000);
    queue_coord(32'h7FFF_0000, 32'hFFFF_8000);
    queue_coord(32'h0012_3456, 32'hFEDC_BA98);
    queue_coord(32'h5555_5555, 32'hAAAA_AAAA);
    queue_coord(32'hAAAA_AAAA, 32'h5555_5555);

    program_settings($urandom, 4'd1, 24'd65536, 16'd8192, 16'd32768, 1'b0);
    set_idling(IDLE_SENDER);
    queue_random_coords(60);

    program_settings(32'h7FFF_FFFF, 4'd8, 24'hFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    set_idling(IDLE_RECEIVER);
    queue_random_coords(60);

    program_settings(32'h8000_0000, 4'd0, 24'd0, 16'd0, 16'd0, 1'b0);
    set_idling(IDLE_BOTH);
    queue_random_coords(60);

    program_settings($urandom, 4'd15, 24'd65536, 16'd8192, 16'd0, 1'b1);
    set_idling(IDLE_NONE);
    queue_random_coords(60);

    program_settings($urandom, 4'd3, 24'd200000, 16'd0, 16'hFFFF, 1'b0);
    set_idling(IDLE_SENDER);
    queue_random_coords(60);

    for (p = 0; p < 17; p++) begin
      octaves = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(1, 6)) : 4'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0: freq = 24'd65536;
        1: freq = 24'($urandom_range(0, 1 << 20));
        2: freq = 24'($urandom);
        default: freq = 24'hFF_FFFF;
      endcase
      case ($urandom_range(0, 4))
        0: lac = 16'd8192;
        1: lac = 16'($urandom_range(2048, 12288));
        2: lac = 16'($urandom);
        3: lac = 16'd0;
        default: lac = 16'hFFFF;
      endcase
      case ($urandom_range(0, 3))
        0: gain = 16'd32768;
        1: gain = 16'($urandom);
        2: gain = 16'd0;
        default: gain = 16'hFFFF;
      endcase
      program_settings($urandom, octaves, freq, lac, gain, p % 5 == 0);
      set_idling(p % 4);
      queue_random_coords(100);
    end

    wait_for_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (noise_expect_q.size() != 0) begin
      $error("%0d noise_value results never arrived", noise_expect_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
